// File: src/bps_pkg.sv
// Shared types, codes and reset constants for the beep pattern sequencer.
// No dependencies; every other file of the block imports this package.
package bps_pkg;

    localparam int DURATION_BITS_DEF = 16;
    localparam int REG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_START    = 2'd1,
        FUNC_STOP     = 2'd2,
        FUNC_READ_CLR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PAT_SINGLE = 2'd0,
        PAT_TRIPLE = 2'd1,
        PAT_IDLE   = 2'd2
    } pattern_t;

    typedef enum logic [1:0] {
        PH_ON    = 2'd0,
        PH_PAUSE = 2'd1,
        PH_LONG  = 2'd2,
        PH_FINAL = 2'd3
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TONE_HZ         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_ON_MS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_PAUSE_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_ON_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_PAUSE_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LONG_MS    = 3'd5;

    localparam logic [REG_W-1:0] TONE_HZ_RST         = 16'd2000;
    localparam logic [REG_W-1:0] BEEP_ON_MS_RST      = 16'd50;
    localparam logic [REG_W-1:0] BEEP_PAUSE_MS_RST   = 16'd100;
    localparam logic [REG_W-1:0] TRIPLE_ON_MS_RST    = 16'd40;
    localparam logic [REG_W-1:0] TRIPLE_PAUSE_MS_RST = 16'd80;
    localparam logic [REG_W-1:0] IDLE_LONG_MS_RST    = 16'd1000;

    localparam logic [2:0] SINGLE_BEEPS = 3'd1;
    localparam logic [2:0] TRIPLE_BEEPS = 3'd3;
    localparam logic [2:0] IDLE_BEEPS   = 3'd4;

    typedef struct packed {
        logic [REG_W-1:0] tone_hz;
        logic [REG_W-1:0] beep_on_ms;
        logic [REG_W-1:0] beep_pause_ms;
        logic [REG_W-1:0] triple_on_ms;
        logic [REG_W-1:0] triple_pause_ms;
        logic [REG_W-1:0] idle_long_pause_ms;
    } cfg_t;

    typedef struct packed {
        func_t      func;
        logic [1:0] pattern;
    } item_t;

    typedef struct packed {
        logic             done_flag;
        logic             busy_res;
        logic [REG_W-1:0] tone_freq;
        logic             tone_on;
    } result_t;

endpackage

// File: src/bps_cfg_regs.sv
// Configuration register file of the beep pattern sequencer.
// Depends on bps_pkg for the register indexes, reset values and cfg_t.
module bps_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bps_pkg::REG_W-1:0]      cfg_data,
    output bps_pkg::cfg_t                  cfg
);
    import bps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TONE_HZ:         cfg_next.tone_hz = cfg_data;
                CFG_BEEP_ON_MS:      cfg_next.beep_on_ms = cfg_data;
                CFG_BEEP_PAUSE_MS:   cfg_next.beep_pause_ms = cfg_data;
                CFG_TRIPLE_ON_MS:    cfg_next.triple_on_ms = cfg_data;
                CFG_TRIPLE_PAUSE_MS: cfg_next.triple_pause_ms = cfg_data;
                CFG_IDLE_LONG_MS:    cfg_next.idle_long_pause_ms = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tone_hz            <= TONE_HZ_RST;
            cfg_reg.beep_on_ms         <= BEEP_ON_MS_RST;
            cfg_reg.beep_pause_ms      <= BEEP_PAUSE_MS_RST;
            cfg_reg.triple_on_ms       <= TRIPLE_ON_MS_RST;
            cfg_reg.triple_pause_ms    <= TRIPLE_PAUSE_MS_RST;
            cfg_reg.idle_long_pause_ms <= IDLE_LONG_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/bps_seq_core.sv
// Sequencer state and the single-pass update for one tick or command.
// Depends on bps_pkg for the codes, phase encoding and item/result types.
module bps_seq_core #(
    parameter int DURATION_BITS = bps_pkg::DURATION_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_fire,
    input  bps_pkg::item_t   item,
    input  bps_pkg::cfg_t    cfg,
    output bps_pkg::result_t result
);
    import bps_pkg::*;

    localparam int CMP_W = (DURATION_BITS > REG_W) ? DURATION_BITS : REG_W;
    localparam logic [DURATION_BITS-1:0] EL_MAX = '1;
    localparam logic [DURATION_BITS-1:0] EL_ONE = DURATION_BITS'(1);

    logic                     running_reg, running_next;
    logic                     done_reg, done_next;
    logic                     gate_reg, gate_next;
    pattern_t                 pat_reg, pat_next;
    phase_t                   phase_reg, phase_next;
    logic [2:0]               beeps_reg, beeps_next;
    logic [DURATION_BITS-1:0] elapsed_reg, elapsed_next;
    logic [REG_W-1:0]         act_on_reg, act_on_next;
    logic [REG_W-1:0]         act_pause_reg, act_pause_next;

    logic [DURATION_BITS-1:0] el_inc;
    logic                     on_hit, pause_hit, long_hit;
    logic [2:0]               beeps_dec;

    assign el_inc    = (elapsed_reg != EL_MAX) ? elapsed_reg + EL_ONE : elapsed_reg;
    assign on_hit    = CMP_W'(el_inc) >= CMP_W'(act_on_reg);
    assign pause_hit = CMP_W'(el_inc) >= CMP_W'(act_pause_reg);
    assign long_hit  = CMP_W'(el_inc) >= CMP_W'(cfg.idle_long_pause_ms);
    assign beeps_dec = beeps_reg - 3'd1;

    always_comb begin
        running_next   = running_reg;
        done_next      = done_reg;
        gate_next      = gate_reg;
        pat_next       = pat_reg;
        phase_next     = phase_reg;
        beeps_next     = beeps_reg;
        elapsed_next   = elapsed_reg;
        act_on_next    = act_on_reg;
        act_pause_next = act_pause_reg;
        if (item_fire) begin
            case (item.func)
                FUNC_TICK: begin
                    if (running_reg) begin
                        elapsed_next = el_inc;
                        unique case (phase_reg)
                            PH_ON: begin
                                if (on_hit) begin
                                    gate_next    = 1'b0;
                                    elapsed_next = '0;
                                    if (beeps_reg > 3'd1) begin
                                        beeps_next = beeps_dec;
                                        phase_next = (pat_reg == PAT_IDLE && beeps_dec == 3'd1)
                                                     ? PH_LONG : PH_PAUSE;
                                    end else begin
                                        running_next = 1'b0;
                                        done_next    = 1'b1;
                                    end
                                end
                            end
                            PH_PAUSE: begin
                                if (pause_hit) begin
                                    phase_next   = PH_ON;
                                    elapsed_next = '0;
                                    gate_next    = 1'b1;
                                end
                            end
                            PH_LONG: begin
                                if (long_hit) begin
                                    phase_next   = PH_FINAL;
                                    elapsed_next = '0;
                                    gate_next    = 1'b1;
                                end
                            end
                            PH_FINAL: begin
                                if (on_hit) begin
                                    gate_next    = 1'b0;
                                    running_next = 1'b0;
                                    done_next    = 1'b1;
                                    elapsed_next = '0;
                                end
                            end
                            default: phase_next = phase_reg;
                        endcase
                    end
                end
                FUNC_START: begin
                    if (!running_reg) begin
                        done_next    = 1'b0;
                        running_next = 1'b1;
                        phase_next   = PH_ON;
                        elapsed_next = '0;
                        gate_next    = 1'b1;
                        if (item.pattern == PAT_TRIPLE) begin
                            pat_next       = PAT_TRIPLE;
                            beeps_next     = TRIPLE_BEEPS;
                            act_on_next    = cfg.triple_on_ms;
                            act_pause_next = cfg.triple_pause_ms;
                        end else if (item.pattern == PAT_IDLE) begin
                            pat_next       = PAT_IDLE;
                            beeps_next     = IDLE_BEEPS;
                            act_on_next    = cfg.beep_on_ms;
                            act_pause_next = cfg.triple_pause_ms;
                        end else begin
                            pat_next       = PAT_SINGLE;
                            beeps_next     = SINGLE_BEEPS;
                            act_on_next    = cfg.beep_on_ms;
                            act_pause_next = cfg.beep_pause_ms;
                        end
                    end
                end
                FUNC_STOP: begin
                    gate_next    = 1'b0;
                    running_next = 1'b0;
                    done_next    = 1'b0;
                    pat_next     = PAT_SINGLE;
                    phase_next   = PH_ON;
                    elapsed_next = '0;
                end
                FUNC_READ_CLR: begin
                    done_next = 1'b0;
                end
                default: done_next = done_reg;
            endcase
        end
    end

    // A read-and-clear reports the flag as it stood before the clear.
    always_comb begin
        result.tone_on   = gate_next;
        result.tone_freq = cfg.tone_hz;
        result.busy_res  = running_next;
        result.done_flag = (item.func == FUNC_READ_CLR) ? done_reg : done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            done_reg      <= 1'b0;
            gate_reg      <= 1'b0;
            pat_reg       <= PAT_SINGLE;
            phase_reg     <= PH_ON;
            beeps_reg     <= '0;
            elapsed_reg   <= '0;
            act_on_reg    <= '0;
            act_pause_reg <= '0;
        end else begin
            running_reg   <= running_next;
            done_reg      <= done_next;
            gate_reg      <= gate_next;
            pat_reg       <= pat_next;
            phase_reg     <= phase_next;
            beeps_reg     <= beeps_next;
            elapsed_reg   <= elapsed_next;
            act_on_reg    <= act_on_next;
            act_pause_reg <= act_pause_next;
        end
    end

endmodule

// File: src/beep_pattern_sequencer_top.sv
// Beep pattern sequencer: takes one beat per clock while the output side is ready,
// returns one result beat per input beat, and holds each accepted beat first in the
// input register and then in the result register; result back-pressure stalls input.
// A tick advances the running pattern by one millisecond; start, stop and the
// finished-flag read-and-clear are commands on the same stream. Configuration
// writes are taken in any cycle and must only be issued while no beat is in flight.
// Depends on bps_pkg, bps_cfg_regs and bps_seq_core.
module beep_pattern_sequencer_top #(
    parameter int DURATION_BITS = bps_pkg::DURATION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bps_pkg::S_TDATA_W-1:0]  s_tdata,   // func[1:0], pattern[3:2], zero fill
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bps_pkg::M_TDATA_W-1:0]  m_tdata,   // tone_on, tone_freq[16:1],
                                                      // busy_res[17], done_flag[18], zero fill
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bps_pkg::REG_W-1:0]      cfg_data
);
    import bps_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg, in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;

    logic    advance;
    logic    fire;
    cfg_t    cfg;
    result_t core_res;

    bps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bps_seq_core #(
        .DURATION_BITS (DURATION_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (fire),
        .item      (in_item_reg),
        .cfg       (cfg),
        .result    (core_res)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.done_flag, out_res_reg.busy_res,
                       out_res_reg.tone_freq, out_res_reg.tone_on};

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tready) begin
            in_valid_next        = s_tvalid;
            in_item_next.func    = func_t'(s_tdata[1:0]);
            in_item_next.pattern = s_tdata[3:2];
        end
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
            out_res_next   = core_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    a_busy_done_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_res_reg.busy_res && out_res_reg.done_flag))
        else $error("Result shows a running sequence that is also finished.");

    a_gate_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.tone_on) |-> out_res_reg.busy_res)
        else $error("Tone gate is on while the sequence is inactive.");

    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("Input stalled although the result side can move.");

    a_result_follows_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("An accepted beat did not reach the result register.");

endmodule

// File: verif/beep_pattern_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for beep_pattern_sequencer_top: streams tick and command beats,
// predicts each status beat with a behavioral sequencer kept here, and compares in order.
// Depends on bps_pkg and the sequencer RTL.
module beep_pattern_sequencer_top_tb;
    import bps_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_BEATS = 185;
    localparam logic [1:0] PAT_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;

    item_t   pending_cmds[$];
    result_t status_due[$];
    item_t   next_cmd;
    item_t   seen_cmd;
    result_t want;
    result_t got;
    int      queued_beats = 0;
    int      accepted_beats = 0;
    int      status_beats = 0;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      in_gap = 0;
    int      out_hold = 0;
    bit      long_hold_done = 1'b0;
    bit      calm = 1'b0;

    cfg_t             regs_shadow;
    logic             run_q;
    logic             done_q;
    logic             gate_q;
    pattern_t         pat_q;
    phase_t           phase_q;
    logic [2:0]       beeps_q;
    logic [REG_W-1:0] elapsed_q;
    logic [REG_W-1:0] on_len_q;
    logic [REG_W-1:0] pause_len_q;

    beep_pattern_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int w;
        w = $urandom_range(0, 99);
        if (w < 60) begin
            return 0;
        end else if (w < 90) begin
            return $urandom_range(1, 3);
        end else if (w < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [REG_W-1:0] rand_ms();
        int w;
        w = $urandom_range(0, 9);
        if (w < 7) begin
            return REG_W'($urandom_range(0, 3));
        end else if (w < 9) begin
            return REG_W'($urandom_range(4, 12));
        end
        return REG_W'($urandom_range(13, 40));
    endfunction

    function automatic result_t step_sequencer(input item_t it);
        result_t  r;
        logic     done_seen;
        pattern_t pat;
        case (it.func)
            FUNC_TICK: begin
                if (run_q) begin
                    if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
                    case (phase_q)
                        PH_ON: begin
                            if (elapsed_q >= on_len_q) begin
                                gate_q = 1'b0;
                                elapsed_q = '0;
                                if (beeps_q > SINGLE_BEEPS) begin
                                    beeps_q = beeps_q - 1'b1;
                                    if (pat_q == PAT_IDLE && beeps_q == SINGLE_BEEPS) begin
                                        phase_q = PH_LONG;
                                    end else begin
                                        phase_q = PH_PAUSE;
                                    end
                                end else begin
                                    run_q = 1'b0;
                                    done_q = 1'b1;
                                end
                            end
                        end
                        PH_PAUSE: begin
                            if (elapsed_q >= pause_len_q) begin
                                phase_q = PH_ON;
                                elapsed_q = '0;
                                gate_q = 1'b1;
                            end
                        end
                        PH_LONG: begin
                            if (elapsed_q >= regs_shadow.idle_long_pause_ms) begin
                                phase_q = PH_FINAL;
                                elapsed_q = '0;
                                gate_q = 1'b1;
                            end
                        end
                        default: begin
                            if (elapsed_q >= on_len_q) begin
                                gate_q = 1'b0;
                                run_q = 1'b0;
                                done_q = 1'b1;
                                elapsed_q = '0;
                            end
                        end
                    endcase
                end
            end
            FUNC_START: begin
                if (!run_q) begin
                    if (it.pattern == PAT_SPARE) begin
                        pat = PAT_SINGLE;
                    end else begin
                        pat = pattern_t'(it.pattern);
                    end
                    done_q = 1'b0;
                    run_q = 1'b1;
                    pat_q = pat;
                    phase_q = PH_ON;
                    case (pat)
                        PAT_TRIPLE: begin
                            beeps_q = TRIPLE_BEEPS;
                            on_len_q = regs_shadow.triple_on_ms;
                            pause_len_q = regs_shadow.triple_pause_ms;
                        end
                        PAT_IDLE: begin
                            beeps_q = IDLE_BEEPS;
                            on_len_q = regs_shadow.beep_on_ms;
                            pause_len_q = regs_shadow.triple_pause_ms;
                        end
                        default: begin
                            beeps_q = SINGLE_BEEPS;
                            on_len_q = regs_shadow.beep_on_ms;
                            pause_len_q = regs_shadow.beep_pause_ms;
                        end
                    endcase
                    elapsed_q = '0;
                    gate_q = 1'b1;
                end
            end
            FUNC_STOP: begin
                gate_q = 1'b0;
                run_q = 1'b0;
                done_q = 1'b0;
                pat_q = PAT_SINGLE;
                phase_q = PH_ON;
                elapsed_q = '0;
            end
            default: begin
            end
        endcase
        done_seen = done_q;
        if (it.func == FUNC_READ_CLR) done_q = 1'b0;
        r.tone_on = gate_q;
        r.tone_freq = regs_shadow.tone_hz;
        r.busy_res = run_q;
        r.done_flag = done_seen;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [REG_W-1:0] exp_val,
                                        input logic [REG_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    task automatic queue_cmd(input func_t f, input logic [1:0] p);
        item_t c;
        c.func = f;
        c.pattern = p;
        pending_cmds.push_back(c);
        queued_beats++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_regs(input cfg_t c, input bit spare);
        write_reg(CFG_TONE_HZ, c.tone_hz);
        write_reg(CFG_BEEP_ON_MS, c.beep_on_ms);
        write_reg(CFG_BEEP_PAUSE_MS, c.beep_pause_ms);
        write_reg(CFG_TRIPLE_ON_MS, c.triple_on_ms);
        write_reg(CFG_TRIPLE_PAUSE_MS, c.triple_pause_ms);
        write_reg(CFG_IDLE_LONG_MS, c.idle_long_pause_ms);
        if (spare) begin
            write_reg(CFG_SPARE_A, REG_W'($urandom));
            write_reg(CFG_SPARE_B, REG_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (accepted_beats != queued_beats || status_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (in_gap > 0) begin
                s_tvalid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_cmds.size() > 0) begin
                next_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(S_TDATA_W - 4){1'b0}}, next_cmd.pattern, next_cmd.func};
                in_gap <= calm ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long hold-off fills the pipeline and backs up the command stream.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_hold <= 0;
        end else if (out_hold > 0) begin
            m_tready <= 1'b0;
            out_hold <= out_hold - 1;
        end else if (!long_hold_done && status_beats >= 300 && pending_cmds.size() > 50) begin
            m_tready <= 1'b0;
            out_hold <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            out_hold <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs_shadow = '{TONE_HZ_RST, BEEP_ON_MS_RST, BEEP_PAUSE_MS_RST, TRIPLE_ON_MS_RST,
                            TRIPLE_PAUSE_MS_RST, IDLE_LONG_MS_RST};
            run_q = 1'b0;
            done_q = 1'b0;
            gate_q = 1'b0;
            pat_q = PAT_SINGLE;
            phase_q = PH_ON;
            beeps_q = '0;
            elapsed_q = '0;
            on_len_q = '0;
            pause_len_q = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                status_beats <= status_beats + 1;
                got = m_tdata[$bits(result_t)-1:0];
                if (status_due.size() == 0) begin
                    $display("%0t: unexpected status beat, expected none, got %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = status_due.pop_front();
                    check_field("tone_on", REG_W'(want.tone_on), REG_W'(got.tone_on));
                    check_field("tone_freq", want.tone_freq, got.tone_freq);
                    check_field("busy_res", REG_W'(want.busy_res), REG_W'(got.busy_res));
                    check_field("done_flag", REG_W'(want.done_flag), REG_W'(got.done_flag));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TONE_HZ:         regs_shadow.tone_hz = cfg_data;
                    CFG_BEEP_ON_MS:      regs_shadow.beep_on_ms = cfg_data;
                    CFG_BEEP_PAUSE_MS:   regs_shadow.beep_pause_ms = cfg_data;
                    CFG_TRIPLE_ON_MS:    regs_shadow.triple_on_ms = cfg_data;
                    CFG_TRIPLE_PAUSE_MS: regs_shadow.triple_pause_ms = cfg_data;
                    CFG_IDLE_LONG_MS:    regs_shadow.idle_long_pause_ms = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                accepted_beats <= accepted_beats + 1;
                seen_cmd.func = func_t'(s_tdata[1:0]);
                seen_cmd.pattern = s_tdata[3:2];
                status_due.push_back(step_sequencer(seen_cmd));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cfg_t setting;
        int   w;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With reset durations no pattern completes here; only command handling is seen.
        queue_cmd(FUNC_READ_CLR, PAT_SINGLE);
        queue_cmd(FUNC_TICK, PAT_IDLE);
        queue_cmd(FUNC_START, PAT_SINGLE);
        queue_cmd(FUNC_START, PAT_TRIPLE);
        queue_cmd(FUNC_TICK, PAT_SINGLE);
        queue_cmd(FUNC_STOP, PAT_SINGLE);
        queue_cmd(FUNC_START, PAT_SPARE);
        queue_cmd(FUNC_STOP, PAT_SPARE);
        drain();

        setting = '{16'hA5A5, 16'd1, 16'd2, 16'd2, 16'd0, 16'd2};
        program_regs(setting, 1'b1);
        queue_cmd(FUNC_START, PAT_IDLE);
        repeat (10) queue_cmd(FUNC_TICK, PAT_SINGLE);
        queue_cmd(FUNC_READ_CLR, PAT_SINGLE);
        queue_cmd(FUNC_READ_CLR, PAT_SINGLE);
        queue_cmd(FUNC_START, PAT_TRIPLE);
        queue_cmd(FUNC_TICK, PAT_SINGLE);
        queue_cmd(FUNC_STOP, PAT_SINGLE);
        queue_cmd(FUNC_READ_CLR, PAT_SINGLE);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                setting = '0;
            end else begin
                setting.tone_hz = REG_W'($urandom);
                setting.beep_on_ms = rand_ms();
                setting.beep_pause_ms = rand_ms();
                setting.triple_on_ms = rand_ms();
                setting.triple_pause_ms = rand_ms();
                setting.idle_long_pause_ms = rand_ms();
            end
            program_regs(setting, ph == 3);
            calm = (ph == 5);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                w = $urandom_range(0, 99);
                if (w < 70) begin
                    queue_cmd(FUNC_TICK, 2'($urandom_range(0, 3)));
                end else if (w < 85) begin
                    queue_cmd(FUNC_START, 2'($urandom_range(0, 3)));
                end else if (w < 90) begin
                    queue_cmd(FUNC_STOP, 2'($urandom_range(0, 3)));
                end else begin
                    queue_cmd(FUNC_READ_CLR, 2'($urandom_range(0, 3)));
                end
            end
            drain();
        end

        // Full-scale durations: the running pattern holds its first beep until the stop.
        calm = 1'b1;
        setting = '1;
        program_regs(setting, 1'b0);
        queue_cmd(FUNC_START, PAT_SINGLE);
        repeat (20) queue_cmd(FUNC_TICK, PAT_SINGLE);
        queue_cmd(FUNC_READ_CLR, PAT_SINGLE);
        queue_cmd(FUNC_START, PAT_TRIPLE);
        queue_cmd(FUNC_TICK, PAT_SINGLE);
        queue_cmd(FUNC_STOP, PAT_SINGLE);
        drain();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/bps_pkg.sv
src/bps_cfg_regs.sv
src/bps_seq_core.sv
src/beep_pattern_sequencer_top.sv
verif/beep_pattern_sequencer_top_tb.sv
